>>> hw/rtl/sfse_pkg.sv
// ----------------------------------------------------------------------------
// sfse_pkg
// Shared types and constants of the screen fade slot engine.
// ----------------------------------------------------------------------------
package sfse_pkg;

  localparam int LEVEL_W  = 5;
  localparam int HOLD_W   = 8;
  localparam int DIR_W    = 3;
  localparam int MASK_W   = 8;

  localparam logic [HOLD_W-1:0]  HOLD_BLACK_INIT = 8'd40;
  localparam logic [HOLD_W-1:0]  HOLD_DONE       = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MAP_TOP   = 5'd30;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 5'd31;
  localparam logic [LEVEL_W-1:0] BLACK_DROP      = 5'd2;
  localparam logic signed [DIR_W-1:0] DIR_POS_LIMIT = 3'sd2;
  localparam logic signed [DIR_W-1:0] DIR_NEG_LIMIT = -3'sd2;

  typedef enum logic [3:0] {
    OP_TICK        = 4'd0,
    OP_CLEAR       = 4'd1,
    OP_MAP_FADE    = 4'd2,
    OP_WHITE_START = 4'd3,
    OP_BLACK_INIT  = 4'd4,
    OP_BLACK_STEP  = 4'd5,
    OP_WHITE_STEP  = 4'd6,
    OP_NORM_INIT   = 4'd7,
    OP_NORM_STEP   = 4'd8,
    OP_REARM       = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    KIND_BLACK = 2'd0,
    KIND_WHITE = 2'd1,
    KIND_NORM  = 2'd2,
    KIND_MAP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_STEP,
    ST_TICK,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic accept;
    logic in_cmd;
    logic in_step;
    logic in_tick;
    logic in_report;
  } ctrl_t;

  typedef struct packed {
    kind_t                     kind;
    logic [HOLD_W-1:0]         hold;
    logic [LEVEL_W-1:0]        level;
    logic signed [DIR_W-1:0]   dir;
    logic                      wipe_done;
  } step_in_t;

  typedef struct packed {
    logic [HOLD_W-1:0]         hold;
    logic [LEVEL_W-1:0]        level;
    logic signed [DIR_W-1:0]   dir;
    logic                      free;
    logic                      fire;
  } step_out_t;

endpackage

>>> hw/rtl/sfse_step.sv
// ----------------------------------------------------------------------------
// sfse_step
// Shared slot step unit: advances one slot by its kind.
// ----------------------------------------------------------------------------
module sfse_step (
  input  sfse_pkg::step_in_t  si,
  output sfse_pkg::step_out_t so
);

  logic [sfse_pkg::LEVEL_W:0]   sum;
  logic [sfse_pkg::LEVEL_W-1:0] mag;
  logic [sfse_pkg::LEVEL_W-1:0] dec;

  always_comb begin
    mag = sfse_pkg::LEVEL_W'(si.dir[sfse_pkg::DIR_W-1] ? -si.dir : si.dir);
    sum = {1'b0, si.level} + {1'b0, mag};
    dec = (si.level > 5'd0) ? si.level - 5'd1 : 5'd0;

    so.hold  = si.hold;
    so.level = si.level;
    so.dir   = si.dir;
    so.free  = 1'b0;
    so.fire  = 1'b0;

    case (si.kind)
      sfse_pkg::KIND_BLACK: begin
        if (si.hold == sfse_pkg::HOLD_DONE) begin
          so.free = 1'b1;
        end else if (si.hold != '0) begin
          so.hold = si.hold - 8'd1;
        end else if (!si.wipe_done) begin
          so.fire = 1'b1;
          so.hold = sfse_pkg::HOLD_DONE;
        end else if (si.level != '0) begin
          so.level = (si.level >= sfse_pkg::BLACK_DROP) ?
                     si.level - sfse_pkg::BLACK_DROP : 5'd0;
        end else begin
          so.hold = sfse_pkg::HOLD_DONE;
        end
      end
      sfse_pkg::KIND_WHITE: begin
        if (si.level < sfse_pkg::LEVEL_MAX) so.level = si.level + 5'd1;
      end
      sfse_pkg::KIND_NORM: begin
        so.level = dec;
        if (dec == '0) so.free = 1'b1;
      end
      sfse_pkg::KIND_MAP: begin
        if (si.dir[sfse_pkg::DIR_W-1]) begin
          // darken: raise level toward the top
          if (sum >= {1'b0, sfse_pkg::LEVEL_MAP_TOP}) begin
            so.level = sfse_pkg::LEVEL_MAP_TOP;
            so.dir   = '0;
          end else begin
            so.level = sum[sfse_pkg::LEVEL_W-1:0];
          end
        end else if (si.dir != '0) begin
          if (si.level <= mag) begin
            so.level = '0;
            so.dir   = '0;
            so.free  = 1'b1;
          end else begin
            so.level = si.level - mag;
          end
        end
      end
      default: begin
        so.level = si.level;
      end
    endcase
  end

endmodule

>>> hw/rtl/sfse_ctrl.sv
// ----------------------------------------------------------------------------
// sfse_ctrl
// Sequencer: command decode, step pass, slot walk for a tick, report.
// ----------------------------------------------------------------------------
module sfse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            is_tick,
  input  logic            need_step,
  input  logic            last,
  output logic            busy,
  output sfse_pkg::ctrl_t ctl
);

  sfse_pkg::state_t state;
  sfse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sfse_pkg::ST_IDLE: begin
        if (start) state_next = is_tick ? sfse_pkg::ST_TICK : sfse_pkg::ST_CMD;
      end
      sfse_pkg::ST_CMD: begin
        state_next = need_step ? sfse_pkg::ST_STEP : sfse_pkg::ST_REPORT;
      end
      sfse_pkg::ST_STEP: begin
        state_next = sfse_pkg::ST_REPORT;
      end
      sfse_pkg::ST_TICK: begin
        if (last) state_next = sfse_pkg::ST_REPORT;
      end
      sfse_pkg::ST_REPORT: begin
        state_next = sfse_pkg::ST_IDLE;
      end
      default: begin
        state_next = sfse_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != sfse_pkg::ST_IDLE);
    ctl.accept    = start && (state == sfse_pkg::ST_IDLE);
    ctl.in_cmd    = (state == sfse_pkg::ST_CMD);
    ctl.in_step   = (state == sfse_pkg::ST_STEP);
    ctl.in_tick   = (state == sfse_pkg::ST_TICK);
    ctl.in_report = (state == sfse_pkg::ST_REPORT);
  end

endmodule

>>> hw/rtl/screen_fade_slot_engine.sv
// ----------------------------------------------------------------------------
// screen_fade_slot_engine
// Table of fade slots stepped by a shared slot step unit.
// ----------------------------------------------------------------------------
// Sequence: a tick walks the slots in ST_TICK, one slot per cycle, then reports;
// a step command passes ST_CMD, ST_STEP and ST_REPORT, any other command ST_CMD
// and ST_REPORT; done is registered from ST_REPORT. A new transaction is not taken
// before the last one has reported; busy is high until the result is registered.
// Reset: rst clears the slot occupancy, map direction and wipe flag.
// The result is shown for one cycle with done high; it cannot be stalled.
module screen_fade_slot_engine #(
  parameter int SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        op,
  input  logic signed [7:0] fade_dir,
  output logic              done,
  output logic [4:0]        black_level,
  output logic [4:0]        white_level,
  output logic [4:0]        normal_level,
  output logic [4:0]        map_level,
  output logic [7:0]        slots_busy,
  output logic              map_fade_active,
  output logic signed [2:0] current_dir,
  output logic              wipe_start
);

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KINDS = 4;

  sfse_pkg::ctrl_t   ctl;
  sfse_pkg::step_in_t  si;
  sfse_pkg::step_out_t so;

  logic [SLOTS-1:0]                  busy_mask;
  sfse_pkg::kind_t                   slot_kind  [SLOTS];
  logic [sfse_pkg::HOLD_W-1:0]       slot_hold  [SLOTS];
  logic [sfse_pkg::LEVEL_W-1:0]      slot_level [SLOTS];
  logic signed [sfse_pkg::DIR_W-1:0] map_direction;
  logic                              wipe_done;
  logic                              wipe_pulse;
  sfse_pkg::op_t                     op_q;
  logic signed [7:0]                 dir_q;
  logic [IW-1:0]                     ptr;

  logic [KINDS-1:0]             found;
  logic [IW-1:0]                found_idx [KINDS];
  logic [sfse_pkg::LEVEL_W-1:0] found_lvl [KINDS];
  logic                         free_ok;
  logic [IW-1:0]                free_idx;
  logic [KINDS-1:0]             take_ok;
  logic [KINDS-1:0]             take_new;
  logic [IW-1:0]                take_idx [KINDS];
  logic [sfse_pkg::LEVEL_W-1:0] take_lvl [KINDS];

  logic                              cmd_wr;
  logic                              cmd_alloc;
  logic [IW-1:0]                     cmd_sel;
  sfse_pkg::kind_t                   cmd_kind;
  logic [sfse_pkg::HOLD_W-1:0]       cmd_hold;
  logic [sfse_pkg::LEVEL_W-1:0]      cmd_level;
  logic                              cmd_need_step;
  logic                              cmd_dir_wr;
  logic signed [sfse_pkg::DIR_W-1:0] cmd_dir;
  logic signed [sfse_pkg::DIR_W-1:0] dir_clamp;
  logic                              apply;
  logic                              last;

  sfse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .is_tick   (sfse_pkg::op_t'(op) == sfse_pkg::OP_TICK),
    .need_step (cmd_need_step),
    .last      (last),
    .busy      (busy),
    .ctl       (ctl)
  );

  sfse_step u_step (
    .si (si),
    .so (so)
  );

  assign last = (ptr == IW'(SLOTS - 1));

  // lowest busy slot of each kind, lowest free slot
  always_comb begin
    for (int k = 0; k < KINDS; k++) begin
      found[k]     = 1'b0;
      found_idx[k] = '0;
      found_lvl[k] = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (busy_mask[i] && slot_kind[i] == sfse_pkg::kind_t'(k)) begin
          found[k]     = 1'b1;
          found_idx[k] = IW'(i);
          found_lvl[k] = slot_level[i];
        end
      end
    end
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_mask[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
    for (int k = 0; k < KINDS; k++) begin
      take_ok[k]  = found[k] || free_ok;
      take_new[k] = !found[k] && free_ok;
      take_idx[k] = found[k] ? found_idx[k] : free_idx;
      take_lvl[k] = found[k] ? found_lvl[k] : '0;
    end
  end

  always_comb begin
    if (dir_q > 8'sd2) begin
      dir_clamp = sfse_pkg::DIR_POS_LIMIT;
    end else if (dir_q < -8'sd2) begin
      dir_clamp = sfse_pkg::DIR_NEG_LIMIT;
    end else begin
      dir_clamp = dir_q[sfse_pkg::DIR_W-1:0];
    end
  end

  always_comb begin
    cmd_wr        = 1'b0;
    cmd_alloc     = 1'b0;
    cmd_sel       = '0;
    cmd_kind      = sfse_pkg::KIND_BLACK;
    cmd_hold      = '0;
    cmd_level     = '0;
    cmd_need_step = 1'b0;
    cmd_dir_wr    = 1'b0;
    cmd_dir       = '0;
    case (op_q)
      sfse_pkg::OP_MAP_FADE: begin
        cmd_dir_wr = 1'b1;
        if (dir_q != '0 && take_ok[sfse_pkg::KIND_MAP]) begin
          cmd_wr    = 1'b1;
          cmd_alloc = take_new[sfse_pkg::KIND_MAP];
          cmd_sel   = take_idx[sfse_pkg::KIND_MAP];
          cmd_kind  = sfse_pkg::KIND_MAP;
          cmd_level = take_lvl[sfse_pkg::KIND_MAP];
          cmd_dir   = dir_clamp;
          if (dir_clamp[sfse_pkg::DIR_W-1]) begin
            if (cmd_level > sfse_pkg::LEVEL_MAP_TOP) cmd_level = sfse_pkg::LEVEL_MAP_TOP;
          end else if (cmd_level == '0) begin
            cmd_level = sfse_pkg::LEVEL_MAP_TOP;
          end
        end
      end
      sfse_pkg::OP_WHITE_START: begin
        cmd_wr    = take_ok[sfse_pkg::KIND_WHITE];
        cmd_alloc = take_new[sfse_pkg::KIND_WHITE];
        cmd_sel   = take_idx[sfse_pkg::KIND_WHITE];
        cmd_kind  = sfse_pkg::KIND_WHITE;
        cmd_level = take_lvl[sfse_pkg::KIND_WHITE];
      end
      sfse_pkg::OP_BLACK_INIT: begin
        cmd_wr        = take_ok[sfse_pkg::KIND_BLACK];
        cmd_alloc     = take_new[sfse_pkg::KIND_BLACK];
        cmd_sel       = take_idx[sfse_pkg::KIND_BLACK];
        cmd_kind      = sfse_pkg::KIND_BLACK;
        cmd_hold      = sfse_pkg::HOLD_BLACK_INIT;
        cmd_level     = sfse_pkg::LEVEL_MAP_TOP;
        cmd_need_step = take_ok[sfse_pkg::KIND_BLACK];
      end
      sfse_pkg::OP_BLACK_STEP: begin
        cmd_sel       = found_idx[sfse_pkg::KIND_BLACK];
        cmd_need_step = found[sfse_pkg::KIND_BLACK];
      end
      sfse_pkg::OP_WHITE_STEP: begin
        cmd_wr        = take_new[sfse_pkg::KIND_WHITE];
        cmd_alloc     = take_new[sfse_pkg::KIND_WHITE];
        cmd_sel       = take_idx[sfse_pkg::KIND_WHITE];
        cmd_kind      = sfse_pkg::KIND_WHITE;
        cmd_need_step = take_ok[sfse_pkg::KIND_WHITE];
      end
      sfse_pkg::OP_NORM_INIT: begin
        cmd_kind  = sfse_pkg::KIND_NORM;
        cmd_level = sfse_pkg::LEVEL_MAX;
        if (found[sfse_pkg::KIND_WHITE]) begin
          cmd_wr  = 1'b1;
          cmd_sel = found_idx[sfse_pkg::KIND_WHITE];
        end else begin
          cmd_wr    = take_ok[sfse_pkg::KIND_NORM];
          cmd_alloc = take_new[sfse_pkg::KIND_NORM];
          cmd_sel   = take_idx[sfse_pkg::KIND_NORM];
        end
      end
      sfse_pkg::OP_NORM_STEP: begin
        cmd_sel       = found_idx[sfse_pkg::KIND_NORM];
        cmd_need_step = found[sfse_pkg::KIND_NORM];
      end
      default: begin
        cmd_wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    si.kind      = slot_kind[ptr];
    si.hold      = slot_hold[ptr];
    si.level     = slot_level[ptr];
    si.dir       = map_direction;
    si.wipe_done = wipe_done;
    apply        = ctl.in_step || (ctl.in_tick && busy_mask[ptr]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_mask     <= '0;
      map_direction <= '0;
      wipe_done     <= 1'b0;
      wipe_pulse    <= 1'b0;
    end else begin
      if (ctl.accept) begin
        op_q       <= sfse_pkg::op_t'(op);
        dir_q      <= fade_dir;
        ptr        <= '0;
        wipe_pulse <= 1'b0;
      end
      if (ctl.in_cmd) begin
        case (op_q)
          sfse_pkg::OP_CLEAR: begin
            busy_mask     <= '0;
            map_direction <= '0;
          end
          sfse_pkg::OP_REARM: begin
            wipe_done <= 1'b0;
          end
          default: begin
            if (cmd_wr) begin
              slot_kind[cmd_sel]  <= cmd_kind;
              slot_hold[cmd_sel]  <= cmd_hold;
              slot_level[cmd_sel] <= cmd_level;
            end
            if (cmd_alloc) busy_mask[cmd_sel] <= 1'b1;
            if (cmd_dir_wr) map_direction <= cmd_dir;
            ptr <= cmd_sel;
          end
        endcase
      end
      if (apply) begin
        if (so.free) begin
          busy_mask[ptr] <= 1'b0;
        end else begin
          slot_hold[ptr]  <= so.hold;
          slot_level[ptr] <= so.level;
        end
        map_direction <= so.dir;
        if (so.fire) begin
          wipe_done  <= 1'b1;
          wipe_pulse <= 1'b1;
        end
      end
      if (ctl.in_tick) ptr <= ptr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.in_report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_report) begin
      black_level     <= found_lvl[sfse_pkg::KIND_BLACK];
      white_level     <= found_lvl[sfse_pkg::KIND_WHITE];
      normal_level    <= found_lvl[sfse_pkg::KIND_NORM];
      map_level       <= found_lvl[sfse_pkg::KIND_MAP];
      slots_busy      <= sfse_pkg::MASK_W'(busy_mask);
      map_fade_active <= (map_direction != '0);
      current_dir     <= map_direction;
      wipe_start      <= wipe_pulse;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a transaction is in progress");

  a_wipe_flag: assert property (@(posedge clk) disable iff (rst)
    (done && wipe_start) |-> wipe_done)
    else $error("wipe pulse without wipe flag set");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (current_dir != 3'sb011 && current_dir != 3'sb100))
    else $error("map direction outside clamp range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: screen fade slot engine testbench
// Drives slot commands and ticks through the start/busy handshake, in bursts
// with random gaps. Each transaction is predicted by a local copy of the slot
// table, and every one-cycle report marked by done is checked field by field
// against the oldest pending prediction. A short stimulus table is walked
// first: reset values, op and direction extremes, and a full table. A
// weighted random mix of commands follows.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS        = 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 16;

  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [4:0] black;
    logic [4:0] white;
    logic [4:0] norm;
    logic [4:0] map;
    logic [7:0] occupancy;
    logic       active;
    logic [2:0] dir;
    logic       wipe;
  } fade_report_t;

  typedef struct {
    logic [3:0]   op;
    logic [7:0]   dir;
    bit           typed;
    fade_report_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [3:0]        op = sfse_pkg::OP_TICK;
  logic signed [7:0] fade_dir = 8'sd0;
  logic              done;
  logic [4:0]        black_level;
  logic [4:0]        white_level;
  logic [4:0]        normal_level;
  logic [4:0]        map_level;
  logic [7:0]        slots_busy;
  logic              map_fade_active;
  logic signed [2:0] current_dir;
  logic              wipe_start;

  screen_fade_slot_engine #(.SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .fade_dir(fade_dir),
    .done(done), .black_level(black_level), .white_level(white_level),
    .normal_level(normal_level), .map_level(map_level), .slots_busy(slots_busy),
    .map_fade_active(map_fade_active), .current_dir(current_dir), .wipe_start(wipe_start)
  );

  always #1 clk = ~clk;

  // Slot table copy
  logic [7:0]      fd_mask;
  sfse_pkg::kind_t fd_kind  [SLOTS];
  logic [7:0]      fd_hold  [SLOTS];
  logic [4:0]      fd_level [SLOTS];
  int              fd_dir;
  logic            fd_wipe_done;
  logic            fd_wipe_pulse;

  fade_report_t reports_due[$];
  stim_row_t    stim_table[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int checked = 0;
  int wipes_seen = 0;
  int drains = 0;

  function automatic int kind_slot(sfse_pkg::kind_t k);
    for (int i = 0; i < SLOTS; i++)
      if (fd_mask[i] && fd_kind[i] == k) return i;
    return -1;
  endfunction

  function automatic void release_slot(int i);
    fd_mask[i]  = 1'b0;
    fd_kind[i]  = sfse_pkg::KIND_BLACK;
    fd_hold[i]  = '0;
    fd_level[i] = '0;
  endfunction

  function automatic int claim_slot(sfse_pkg::kind_t k);
    int s;
    s = kind_slot(k);
    if (s >= 0) return s;
    for (int i = 0; i < SLOTS; i++) begin
      if (!fd_mask[i]) begin
        fd_mask[i]  = 1'b1;
        fd_kind[i]  = k;
        fd_hold[i]  = '0;
        fd_level[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void step_black(int i);
    if (fd_hold[i] == sfse_pkg::HOLD_DONE) begin
      release_slot(i);
    end else if (fd_hold[i] != 0) begin
      fd_hold[i] = fd_hold[i] - 8'd1;
    end else if (!fd_wipe_done) begin
      fd_wipe_done  = 1'b1;
      fd_wipe_pulse = 1'b1;
      fd_hold[i]    = sfse_pkg::HOLD_DONE;
    end else if (fd_level[i] != 0) begin
      fd_level[i] = (fd_level[i] >= sfse_pkg::BLACK_DROP) ?
                    fd_level[i] - sfse_pkg::BLACK_DROP : 5'd0;
    end else begin
      fd_hold[i] = sfse_pkg::HOLD_DONE;
    end
  endfunction

  function automatic void step_white(int i);
    if (fd_level[i] < sfse_pkg::LEVEL_MAX) fd_level[i] = fd_level[i] + 5'd1;
  endfunction

  function automatic void step_norm(int i);
    if (fd_level[i] > 0) fd_level[i] = fd_level[i] - 5'd1;
    if (fd_level[i] == 0) release_slot(i);
  endfunction

  function automatic void step_map(int i);
    int lv;
    int top;
    lv  = int'(fd_level[i]);
    top = int'(sfse_pkg::LEVEL_MAP_TOP);
    if (fd_dir == 0) return;
    if (fd_dir < 0) begin
      lv = lv - fd_dir;
      if (lv >= top) lv = top;
      fd_level[i] = 5'(lv);
      if (lv >= top) fd_dir = 0;
      return;
    end
    if (lv <= fd_dir) lv = 0;
    else lv = lv - fd_dir;
    fd_level[i] = 5'(lv);
    if (lv == 0) begin
      fd_dir = 0;
      release_slot(i);
    end
  endfunction

  function automatic void start_map_fade(int d);
    int s;
    int lim;
    lim = int'(sfse_pkg::DIR_POS_LIMIT);
    if (d == 0) begin
      fd_dir = 0;
      return;
    end
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    s = claim_slot(sfse_pkg::KIND_MAP);
    if (s < 0) begin
      fd_dir = 0;
      return;
    end
    fd_hold[s] = '0;
    if (d < 0) begin
      if (fd_level[s] > sfse_pkg::LEVEL_MAP_TOP) fd_level[s] = sfse_pkg::LEVEL_MAP_TOP;
    end else if (fd_level[s] == 0) begin
      fd_level[s] = sfse_pkg::LEVEL_MAP_TOP;
    end
    fd_dir = d;
  endfunction

  function automatic logic [4:0] kind_level(sfse_pkg::kind_t k);
    int s;
    s = kind_slot(k);
    return (s < 0) ? 5'd0 : fd_level[s];
  endfunction

  function automatic fade_report_t advance_fade(logic [3:0] o, logic signed [7:0] d);
    fade_report_t r;
    int s;
    fd_wipe_pulse = 1'b0;
    case (o)
      sfse_pkg::OP_TICK: begin
        for (s = 0; s < SLOTS; s++) begin
          if (fd_mask[s]) begin
            case (fd_kind[s])
              sfse_pkg::KIND_BLACK: step_black(s);
              sfse_pkg::KIND_WHITE: step_white(s);
              sfse_pkg::KIND_NORM:  step_norm(s);
              default:              step_map(s);
            endcase
          end
        end
      end
      sfse_pkg::OP_CLEAR: begin
        for (s = 0; s < SLOTS; s++) release_slot(s);
        fd_dir = 0;
      end
      sfse_pkg::OP_MAP_FADE: start_map_fade(int'(d));
      sfse_pkg::OP_WHITE_START: begin
        s = claim_slot(sfse_pkg::KIND_WHITE);
        if (s >= 0) fd_hold[s] = '0;
      end
      sfse_pkg::OP_BLACK_INIT: begin
        s = claim_slot(sfse_pkg::KIND_BLACK);
        if (s >= 0) begin
          fd_hold[s]  = sfse_pkg::HOLD_BLACK_INIT;
          fd_level[s] = sfse_pkg::LEVEL_MAP_TOP;
          step_black(s);
        end
      end
      sfse_pkg::OP_BLACK_STEP: begin
        s = kind_slot(sfse_pkg::KIND_BLACK);
        if (s >= 0) step_black(s);
      end
      sfse_pkg::OP_WHITE_STEP: begin
        s = claim_slot(sfse_pkg::KIND_WHITE);
        if (s >= 0) step_white(s);
      end
      sfse_pkg::OP_NORM_INIT: begin
        s = kind_slot(sfse_pkg::KIND_WHITE);
        if (s < 0) s = claim_slot(sfse_pkg::KIND_NORM);
        if (s >= 0) begin
          fd_kind[s]  = sfse_pkg::KIND_NORM;
          fd_hold[s]  = '0;
          fd_level[s] = sfse_pkg::LEVEL_MAX;
        end
      end
      sfse_pkg::OP_NORM_STEP: begin
        s = kind_slot(sfse_pkg::KIND_NORM);
        if (s >= 0) step_norm(s);
      end
      sfse_pkg::OP_REARM: fd_wipe_done = 1'b0;
      default: ;
    endcase
    r.black     = kind_level(sfse_pkg::KIND_BLACK);
    r.white     = kind_level(sfse_pkg::KIND_WHITE);
    r.norm      = kind_level(sfse_pkg::KIND_NORM);
    r.map       = kind_level(sfse_pkg::KIND_MAP);
    r.occupancy = fd_mask;
    r.active    = (fd_dir != 0);
    r.dir       = 3'(fd_dir);
    r.wipe      = fd_wipe_pulse;
    return r;
  endfunction

  function automatic fade_report_t report_of(logic [4:0] b, logic [4:0] w, logic [4:0] n,
                                             logic [4:0] m, logic [7:0] occ);
    fade_report_t r;
    r = '0;
    r.black     = b;
    r.white     = w;
    r.norm      = n;
    r.map       = m;
    r.occupancy = occ;
    return r;
  endfunction

  function automatic void add_row(logic [3:0] o, logic [7:0] d, bit typed,
                                  fade_report_t want);
    stim_row_t row;
    row.op    = o;
    row.dir   = d;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endfunction

  // Hold start high until the transaction is taken; start is not lowered here.
  task automatic issue(input logic [3:0] o, input logic [7:0] d, input bit typed,
                       input fade_report_t want);
    fade_report_t predicted;
    start    <= 1'b1;
    op       <= o;
    fade_dir <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = advance_fade(o, d);
    reports_due.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic hold_off(input int n);
    start    <= 1'b0;
    op       <= 4'($urandom);
    fade_dir <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
    drains++;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d reports pending", cycles,
               reports_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    fade_report_t want;
    if (!rst && done) begin
      if (wipe_start === 1'b1) wipes_seen++;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none, actual occupancy %0h",
                 $time, slots_busy);
      end else begin
        want = reports_due.pop_front();
        cmp_field("black_level", 8'(want.black), 8'(black_level));
        cmp_field("white_level", 8'(want.white), 8'(white_level));
        cmp_field("normal_level", 8'(want.norm), 8'(normal_level));
        cmp_field("map_level", 8'(want.map), 8'(map_level));
        cmp_field("slots_busy", want.occupancy, slots_busy);
        cmp_field("map_fade_active", 8'(want.active), 8'(map_fade_active));
        cmp_field("current_dir", 8'(want.dir), 8'($unsigned(current_dir)));
        cmp_field("wipe_start", 8'(want.wipe), 8'(wipe_start));
        checked++;
      end
    end
  end

  initial begin
    fade_report_t none;
    logic [3:0] o;
    logic [7:0] d;
    int useful;
    int burst;
    int pick;

    none          = '0;
    fd_mask       = '0;
    fd_dir        = 0;
    fd_wipe_done  = 1'b0;
    fd_wipe_pulse = 1'b0;
    for (int i = 0; i < SLOTS; i++) release_slot(i);

    add_row(sfse_pkg::OP_TICK,        8'h00, 1'b1, none);
    add_row(sfse_pkg::OP_REARM,       8'h00, 1'b1, none);
    add_row(OP_UNUSED_HI,             8'h80, 1'b1, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'h00, 1'b1, none);
    add_row(OP_UNUSED_LO,             8'h7F, 1'b1, none);
    add_row(sfse_pkg::OP_BLACK_INIT,  8'hFF, 1'b1,
            report_of(5'd30, 5'd0, 5'd0, 5'd0, 8'h01));
    add_row(sfse_pkg::OP_BLACK_STEP,  8'h55, 1'b0, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'h7F, 1'b0, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'h80, 1'b0, none);
    add_row(sfse_pkg::OP_TICK,        8'hAA, 1'b0, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'h01, 1'b0, none);
    add_row(sfse_pkg::OP_TICK,        8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'hFF, 1'b0, none);
    add_row(sfse_pkg::OP_WHITE_START, 8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_WHITE_STEP,  8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_NORM_INIT,   8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_NORM_STEP,   8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_WHITE_STEP,  8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_CLEAR,       8'h00, 1'b1, none);
    add_row(sfse_pkg::OP_WHITE_START, 8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_NORM_INIT,   8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_WHITE_START, 8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_NORM_INIT,   8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_WHITE_START, 8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_BLACK_INIT,  8'h00, 1'b0, none);
    add_row(sfse_pkg::OP_MAP_FADE,    8'h02, 1'b1,
            report_of(5'd30, 5'd0, 5'd31, 5'd0, 8'h0F));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[k])
      issue(stim_table[k].op, stim_table[k].dir, stim_table[k].typed, stim_table[k].want);
    drain_reports();

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if      (pick < 38) o = sfse_pkg::OP_TICK;
        else if (pick < 40) o = sfse_pkg::OP_CLEAR;
        else if (pick < 48) o = sfse_pkg::OP_MAP_FADE;
        else if (pick < 53) o = sfse_pkg::OP_WHITE_START;
        else if (pick < 60) o = sfse_pkg::OP_BLACK_INIT;
        else if (pick < 72) o = sfse_pkg::OP_BLACK_STEP;
        else if (pick < 78) o = sfse_pkg::OP_WHITE_STEP;
        else if (pick < 84) o = sfse_pkg::OP_NORM_INIT;
        else if (pick < 92) o = sfse_pkg::OP_NORM_STEP;
        else if (pick < 96) o = sfse_pkg::OP_REARM;
        else                o = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if ($urandom_range(0, 9) < 4) d = 8'($urandom_range(0, 255));
        else d = 8'($urandom_range(0, 6)) - 8'd3;
        issue(o, d, 1'b0, none);
        if (o < OP_UNUSED_LO) useful++;
      end
      if ($urandom_range(0, 149) == 0) drain_reports();
      else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 10));
    end

    drain_reports();
    repeat (SETTLE) @(posedge clk);
    if (reports_due.size() != 0) begin
      errors++;
      $display("%0t: %0d reports never arrived", $time, reports_due.size());
    end
    $display("tb: %0d transactions sent, %0d reports checked, %0d errors", sent, checked,
             errors);
    $display("tb: %0d wipe pulses observed, %0d full drains", wipes_seen, drains);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
